// ----- design/fsnt_pkg.sv -----
// Package: sequencer state, search phase and divider status types for the factor splitter.
package fsnt_pkg;

    localparam int unsigned TARGET_FLOOR = 2;
    localparam int unsigned TARGET_RESET = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_TARGET,
        PH_BELOW,
        PH_ABOVE
    } t_phase;

    typedef struct packed {
        logic done;
        logic exact;
    } t_div_stat;

endpackage

// ----- design/fsnt_stream_if.sv -----
// Interfaces: request channel carrying a process count, result channel carrying one factor.
interface fsnt_count_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] proc_count;

    modport source (output valid, output proc_count, input ready);
    modport sink   (input valid, input proc_count, output ready);
endinterface

interface fsnt_factor_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] factor;
    logic                  factor_valid;
    logic                  last;

    modport source (output valid, output factor, output factor_valid, output last, input ready);
    modport sink   (input valid, input factor, input factor_valid, input last, output ready);
endinterface

// ----- design/factor_split_near_target.sv -----
// Top level: splits a process count into factors near a configured target, one trial division at a time.
// Each trial division runs on the shared restoring divider.
// A factor costs one division for the target, up to target-2 below it, and up to R-target-1 above it.
// A count of 0 or 1 skips the divider and gives a single empty marker as its last result.
// One request at a time: ready is low from acceptance until the last result has been taken.
// Reset is synchronous, active low: the block goes idle and the target returns to 8.
module factor_split_near_target #(
    parameter int COUNT_BITS  = 16,
    parameter int TARGET_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TARGET_BITS-1:0] i_cfg_data,
    fsnt_count_if.sink             i_req,
    fsnt_factor_if.source          o_res
);
    import fsnt_pkg::*;

    localparam int D_BITS = ((COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS) + 1;

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [TARGET_BITS-1:0] r_target;
    logic [COUNT_BITS-1:0]  r_rem, n_rem;
    logic [D_BITS-1:0]      r_d, n_d;
    logic                   r_start, n_start;
    logic [COUNT_BITS-1:0]  r_factor, n_factor;
    logic                   r_fv, n_fv;
    logic                   r_last, n_last;

    logic [TARGET_BITS-1:0] w_teff;
    logic [D_BITS-1:0]      w_text;
    logic [D_BITS-1:0]      w_above_d;
    logic                   w_above_ok;
    logic [COUNT_BITS-1:0]  w_quo;
    t_div_stat              w_stat;

    assign w_teff     = (r_target < TARGET_BITS'(TARGET_FLOOR)) ? TARGET_BITS'(TARGET_FLOOR)
                                                                 : r_target;
    assign w_text     = D_BITS'(w_teff);
    assign w_above_d  = (r_phase == PH_ABOVE) ? r_d + D_BITS'(1) : w_text + D_BITS'(1);
    assign w_above_ok = w_above_d < D_BITS'(r_rem);

    fsnt_div #(
        .COUNT_BITS (COUNT_BITS),
        .D_BITS     (D_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_rem),
        .i_divisor  (r_d),
        .o_quotient (w_quo),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_TARGET;
            r_start  <= 1'b0;
            r_target <= TARGET_BITS'(TARGET_RESET);
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_start <= n_start;
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
        end
        r_rem    <= n_rem;
        r_d      <= n_d;
        r_factor <= n_factor;
        r_fv     <= n_fv;
        r_last   <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_d         = r_d;
        n_start     = 1'b0;
        n_factor    = r_factor;
        n_fv        = r_fv;
        n_last      = r_last;
        i_req.ready = 1'b0;
        o_res.valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_rem = i_req.proc_count;
                    if (i_req.proc_count <= COUNT_BITS'(1)) begin
                        n_factor = '0;
                        n_fv     = 1'b0;
                        n_last   = 1'b1;
                        n_state  = ST_EMIT;
                    end else begin
                        n_d     = w_text;
                        n_phase = PH_TARGET;
                        n_start = 1'b1;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    if (w_stat.exact) begin
                        // take the divisor, advance the remainder
                        n_factor = r_d[COUNT_BITS-1:0];
                        n_fv     = 1'b1;
                        n_rem    = w_quo;
                        n_last   = (w_quo == COUNT_BITS'(1));
                        n_state  = ST_EMIT;
                    end else if (r_phase == PH_TARGET && w_text > D_BITS'(2)) begin
                        n_d     = w_text - D_BITS'(1);
                        n_phase = PH_BELOW;
                        n_start = 1'b1;
                    end else if (r_phase == PH_BELOW && r_d > D_BITS'(2)) begin
                        n_d     = r_d - D_BITS'(1);
                        n_start = 1'b1;
                    end else if (w_above_ok) begin
                        n_d     = w_above_d;
                        n_phase = PH_ABOVE;
                        n_start = 1'b1;
                    end else begin
                        // no divisor left below the remainder: take the remainder itself
                        n_factor = r_rem;
                        n_fv     = 1'b1;
                        n_rem    = COUNT_BITS'(1);
                        n_last   = 1'b1;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_res.valid = 1'b1;
                if (o_res.ready) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_d     = w_text;
                        n_phase = PH_TARGET;
                        n_start = 1'b1;
                        n_state = ST_DIV;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.factor       = r_factor;
    assign o_res.factor_valid = r_fv;
    assign o_res.last         = r_last;

endmodule

// ----- design/fsnt_div.sv -----
// Restoring divider: one quotient bit a cycle, reports quotient and whether the division is exact.
module fsnt_div #(
    parameter int COUNT_BITS = 16,
    parameter int D_BITS     = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_dividend,
    input  logic [D_BITS-1:0]     i_divisor,
    output logic [COUNT_BITS-1:0] o_quotient,
    output fsnt_pkg::t_div_stat   o_stat
);
    import fsnt_pkg::*;

    localparam int CNT_BITS = $clog2(COUNT_BITS);

    logic [D_BITS-1:0]     r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_quo, n_quo;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [D_BITS:0]       w_trial;
    logic [D_BITS:0]       w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[COUNT_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CNT_BITS'(COUNT_BITS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[D_BITS-1:0] : w_trial[D_BITS-1:0];
            n_quo = {r_quo[COUNT_BITS-2:0], w_ge};
            n_cnt = r_cnt - CNT_BITS'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_quotient   = r_quo;
    assign o_stat.done  = r_done;
    assign o_stat.exact = (r_rem == '0);

endmodule

// ----- design/fsnt_checker.sv -----
// Checker: port-level properties of the factor splitter, bound to the top level.
module fsnt_checker #(
    parameter int COUNT_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COUNT_BITS-1:0] i_factor,
    input logic                  i_factor_valid,
    input logic                  i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_factor)
            && $stable(i_factor_valid) && $stable(i_last))
        else $error("stalled result changed");

    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready after accepting a request");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_factor_valid |-> i_last && i_factor == '0)
        else $error("empty marker malformed");

    a_factor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_factor_valid |-> i_factor >= COUNT_BITS'(2))
        else $error("factor below two");

endmodule

bind factor_split_near_target fsnt_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_fsnt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_factor       (o_res.factor),
    .i_factor_valid (o_res.factor_valid),
    .i_last         (o_res.last)
);

// ----- test/tb_factor_split_near_target.sv -----
// Testbench: drives process counts and target settings into the factor splitter and checks every factor.
module tb_factor_split_near_target;
    import fsnt_pkg::*;

    localparam int CNT_W       = 16;
    localparam int TGT_W       = 8;
    localparam int MAX_DIVS    = 4000;
    localparam int QUIET_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CNT_W-1:0] factor;
        logic             factor_valid;
        logic             last;
    } t_factor_res;

    typedef t_factor_res t_run_q[$];

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [TGT_W-1:0] i_cfg_data = '0;

    logic [TGT_W-1:0] target_shadow = TGT_W'(TARGET_RESET);
    t_factor_res      factor_q[$];
    int               fail_count   = 0;
    int               quiet_cycles = 0;
    bit               steady       = 1'b0;
    bit               hold_req     = 1'b0;

    fsnt_count_if  #(.COUNT_BITS(CNT_W)) req_if ();
    fsnt_factor_if #(.COUNT_BITS(CNT_W)) res_if ();

    factor_split_near_target #(
        .COUNT_BITS(CNT_W),
        .TARGET_BITS(TGT_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_req(req_if),
        .o_res(res_if)
    );

    always #6 i_clk = ~i_clk;

    function automatic void factor_run(input logic [CNT_W-1:0] count,
                                       input logic [TGT_W-1:0] tgt_reg,
                                       output t_run_q run, output int divs);
        int unsigned rem;
        int unsigned tgt;
        int unsigned d;
        t_factor_res r;
        run = {};
        divs = 0;
        tgt = (tgt_reg < TARGET_FLOOR) ? TARGET_FLOOR : tgt_reg;
        rem = count;
        if (rem <= 1) begin
            r = '{factor: '0, factor_valid: 1'b0, last: 1'b1};
            run = {run, r};
            return;
        end
        while (rem > 1) begin
            divs++;
            d = tgt;
            if (rem % tgt != 0) begin
                d = tgt - 1;
                while (d > 1 && rem % d != 0) begin
                    divs++;
                    d--;
                end
                if (d <= 1) begin
                    d = tgt + 1;
                    while (d < rem && rem % d != 0) begin
                        divs++;
                        d++;
                    end
                    if (d > rem) d = rem;
                end
            end
            rem = rem / d;
            r = '{factor: CNT_W'(d), factor_valid: 1'b1, last: (rem == 1)};
            run = {run, r};
        end
    endfunction

    // Mostly products of factors near the target; drop counts whose search runs too long.
    function automatic logic [CNT_W-1:0] random_count();
        t_run_q run;
        int divs;
        int unsigned p;
        int unsigned f;
        int pick;
        logic [CNT_W-1:0] count;
        do begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                p = 1;
                do begin
                    case ($urandom_range(3))
                        0: f = target_shadow;
                        1: f = $urandom_range(2, 8);
                        2: f = $urandom_range(2, 40);
                        default: f = target_shadow + $urandom_range(1, 12);
                    endcase
                    if (f < 2) f = 2;
                    if (p * f <= (1 << CNT_W) - 1) p = p * f;
                end while ($urandom_range(4) != 0);
                count = CNT_W'(p);
            end else if (pick < 80) begin
                count = CNT_W'($urandom_range(0, 300));
            end else begin
                count = CNT_W'($urandom);
            end
            factor_run(count, target_shadow, run, divs);
        end while (divs > MAX_DIVS);
        return count;
    endfunction

    task automatic send_count(input logic [CNT_W-1:0] count);
        t_run_q run;
        int divs;
        if (!steady && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.proc_count <= count;
        do @(posedge i_clk); while (!req_if.ready);
        factor_run(count, target_shadow, run, divs);
        foreach (run[k]) factor_q = {factor_q, run[k]};
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (factor_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [TGT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        target_shadow = value;
    endtask

    task automatic test_reset_target();
        logic [CNT_W-1:0] counts [11] = '{0, 1, 2, 8, 64, 7, 12, 13, 65535, 65534, 8191};
        foreach (counts[k]) send_count(counts[k]);
        drain();
    endtask

    task automatic test_target_extremes();
        logic [CNT_W-1:0] at_zero [4] = '{2, 9, 1024, 65535};
        logic [CNT_W-1:0] at_one [3]  = '{3, 96, 32768};
        logic [CNT_W-1:0] at_top [5]  = '{255, 65535, 254, 257, 1};
        write_target(0);
        foreach (at_zero[k]) send_count(at_zero[k]);
        drain();
        write_target(1);
        foreach (at_one[k]) send_count(at_one[k]);
        drain();
        write_target(255);
        foreach (at_top[k]) send_count(at_top[k]);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_target(TGT_W'($urandom_range(2, 16)));
                2: write_target(TGT_W'(TARGET_FLOOR));
                4: write_target(TGT_W'($urandom_range(2, 32)));
                default: write_target(TGT_W'($urandom_range(0, 255)));
            endcase
            steady = (ph == 2);
            repeat (15) send_count(random_count());
            drain();
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (6) send_count(CNT_W'($urandom_range(2, 600)));
        steady = 1'b0;
        drain();
    endtask

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_if.ready <= steady || ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin : check_res
        t_factor_res got;
        t_factor_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{factor: res_if.factor, factor_valid: res_if.factor_valid, last: res_if.last};
            if (factor_q.size() == 0) begin
                $display("%0t: expected none, got factor %0d valid %0b last %0b",
                         $time, got.factor, got.factor_valid, got.last);
                fail_count++;
            end else begin
                want = factor_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected factor %0d valid %0b last %0b, got factor %0d valid %0b last %0b",
                             $time, want.factor, want.factor_valid, want.last,
                             got.factor, got.factor_valid, got.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        req_if.valid      = 1'b0;
        req_if.proc_count = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_target();
        test_target_extremes();
        test_random();
        test_backpressure();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && factor_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
